### hdl/gida_pkg.sv
// Shared constants, codes and types of the group id assigner.
`timescale 1ns / 1ps

package gida_pkg;

  // Field widths of the row and result words
  localparam int KEY_VALUE_W = 64;
  localparam int GID_W       = 11;
  localparam int ROW_CNT_W   = 32;
  localparam int STATUS_W    = 2;

  // Hash table geometry
  localparam int TABLE_SIZE  = 1024;
  localparam int KEY_WIDTH_DEF = 64;
  localparam int CELLS       = 4;
  localparam int ROWS        = TABLE_SIZE / CELLS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int OFF_W       = $clog2(CELLS);
  localparam int CNT_W       = $clog2(ROWS + 1);
  localparam int GROUP_CAP   = (TABLE_SIZE < 1024) ? TABLE_SIZE : 1024;
  localparam int GRP_W       = $clog2(GROUP_CAP);
  localparam int GCNT_W      = $clog2(GROUP_CAP + 1);

  // Table epochs; epoch zero marks a slot that was swept and never used
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;

  // Hash constants
  localparam int HASH_W     = 64;
  localparam int HASH_SHIFT = 29;
  localparam int HASH_FOLD  = 32;
  localparam logic [HASH_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam int PROD_W = HASH_FOLD + SLOT_W;
  localparam int HALF_W = (PROD_W + 1) / 2;
  localparam int HIGH_W = PROD_W - HALF_W;

  // Result codes
  localparam logic [STATUS_W-1:0] STATUS_GROUPED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic signed [GID_W-1:0] GID_NONE   = -11'sd1;

  // Per slot bookkeeping stored next to the key
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               key_null;
    logic [GRP_W-1:0]   group;
  } meta_t;

  // Memory access shared by all cells
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    meta_t            wr_meta;
  } cell_ctrl_t;

  // Lookup attributes besides the key
  typedef struct packed {
    logic               key_null;
    logic [EPOCH_W-1:0] epoch;
  } look_t;

  // Probe decision handed from cell to cell
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [OFF_W-1:0] bank;
    logic [GRP_W-1:0] group;
  } chain_t;

endpackage

### hdl/gida_if.sv
// Channel interfaces of the group id assigner: rows, results, configuration.
`timescale 1ns / 1ps

interface gida_row_if import gida_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KEY_VALUE_W-1:0] key_value;
  logic                   key_null;
  logic                   start_table;

  modport source (output valid, output key_value, output key_null, output start_table,
                  input ready);
  modport sink (input valid, input key_value, input key_null, input start_table,
                output ready);
endinterface

interface gida_res_if import gida_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [GID_W-1:0]   group_id;
  logic                      new_group;
  logic [ROW_CNT_W-1:0]      row_index;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output group_id, output new_group, output row_index,
                  output status, input ready);
  modport sink (input valid, input group_id, input new_group, input row_index,
                input status, output ready);
endinterface

interface gida_cfg_if ();
  logic valid;
  logic ready;
  logic drop_null_keys;

  modport source (output valid, output drop_null_keys, input ready);
  modport sink (input valid, input drop_null_keys, output ready);
endinterface

### hdl/gida_hash.sv
// Two stage home slot hash: split multiply, then fold and reduce.
`timescale 1ns / 1ps

module gida_hash import gida_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              load,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic              key_null,
  output logic [SLOT_W-1:0] slot
);

  logic [HASH_W-1:0] key_ext;
  logic [HASH_W-1:0] mix;
  logic [PROD_W-1:0] m_ll;
  logic [HALF_W-1:0] m_lh;
  logic [HALF_W-1:0] m_hl;
  logic [PROD_W-1:0] p_ll;
  logic [HALF_W-1:0] p_lh;
  logic [HALF_W-1:0] p_hl;
  logic              null_r;
  logic [HALF_W-1:0] mid;
  logic [PROD_W-1:0] prod;

  // Premix and partial products; only the low PROD_W product bits matter
  assign key_ext = HASH_W'(key);
  assign mix     = key_ext ^ (key_ext >> HASH_SHIFT);
  assign m_ll = PROD_W'(mix[HALF_W-1:0]) * PROD_W'(HASH_MULT[HALF_W-1:0]);
  assign m_lh = mix[HALF_W-1:0] * HALF_W'(HASH_MULT[PROD_W-1:HALF_W]);
  assign m_hl = HALF_W'(mix[PROD_W-1:HALF_W]) * HASH_MULT[HALF_W-1:0];

  // Capture the partial products with the accepted row
  always_ff @(posedge clk) begin
    if (load) begin
      p_ll   <= m_ll;
      p_lh   <= m_lh;
      p_hl   <= m_hl;
      null_r <= key_null;
    end
  end

  // Recombine, fold the high word down and keep the slot bits
  assign mid  = p_lh + p_hl;
  assign prod = p_ll + {mid[HIGH_W-1:0], {HALF_W{1'b0}}};
  assign slot = prod[SLOT_W-1:0] ^ prod[HASH_FOLD +: SLOT_W] ^ SLOT_W'(null_r);

endmodule

### hdl/gida_cell.sv
// One probe cell: a bank of table slots, its compare, and its link in the chain.
`timescale 1ns / 1ps

module gida_cell import gida_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic                 wr_en,
  input  logic [KEY_WIDTH-1:0] key,
  input  look_t                look,
  input  logic                 in_window,
  input  chain_t               chain_in,
  output chain_t               chain_out
);

  logic [KEY_WIDTH-1:0] key_mem [ROWS];
  meta_t                meta_mem [ROWS];
  logic [KEY_WIDTH-1:0] rd_key;
  meta_t                rd_meta;
  logic                 used;
  logic                 match;
  logic                 stop;

  // Bank write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[ctrl.wr_row]  <= key;
      meta_mem[ctrl.wr_row] <= ctrl.wr_meta;
    end
    if (ctrl.rd_en) begin
      rd_key  <= key_mem[ctrl.rd_row];
      rd_meta <= meta_mem[ctrl.rd_row];
    end
  end

  // A slot is in use only if written in the current epoch
  assign used  = (rd_meta.epoch == look.epoch);
  assign match = used && (rd_key == key) && (rd_meta.key_null == look.key_null);
  assign stop  = in_window && (!used || match);

  // Claim the decision unless a cell earlier in probe order already did
  always_comb begin
    if (!chain_in.done && stop) begin
      chain_out = '{done: 1'b1, hit: match, bank: OFF_W'(CELL_IDX), group: rd_meta.group};
    end else begin
      chain_out = chain_in;
    end
  end

endmodule

### hdl/group_id_assigner_core.sv
// Top level of the group id assigner: hash probe sequencer over a chain of cells.
`timescale 1ns / 1ps
//
//  channel   dir  handshake      word
//  row_in    in   valid/ready    key_value[63:0], key_null, start_table
//  result    out  valid/ready    group_id[10:0] signed, new_group, row_index[31:0], status[1:0]
//  cfg       in   valid/ready    drop_null_keys (ready always high)
//
//  A row whose probe resolves in the first table row of four slots passes accept, hash and
//  read, and compare; each further row of four slots probed adds a read and compare.
//  A dropped null key skips the probe. The compare chain of the four cells sets the step.
//  After reset a sweep over every table row marks every slot free; a table start that wraps
//  the 8 bit epoch runs the same sweep before its row is probed.
//  A result held by a stalled sink holds the sequencer; the next row is still accepted
//  while the output register waits.

module group_id_assigner_core import gida_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  gida_row_if.sink       row_in,
  gida_res_if.source     result,
  gida_cfg_if.sink       cfg
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  state_t                   state;
  logic                     drop_null_keys;
  logic [EPOCH_W-1:0]       epoch;
  logic [GCNT_W-1:0]        group_count;
  logic [ROW_CNT_W-1:0]     row_count;
  logic                     item_held;
  logic [ROW_W-1:0]         clr_row;
  logic [KEY_WIDTH-1:0]     key_r;
  logic                     null_r;
  logic                     drop_r;
  logic [ROW_CNT_W-1:0]     row_idx_r;
  logic [ROW_W-1:0]         probe_row;
  logic [OFF_W-1:0]         probe_off;
  logic [CNT_W-1:0]         probe_cnt;
  logic                     out_valid;
  logic signed [GID_W-1:0]  out_gid;
  logic                     out_new;
  logic [ROW_CNT_W-1:0]     out_row;
  logic [STATUS_W-1:0]      out_status;

  logic                     accept;
  logic [ROW_CNT_W-1:0]     row_base;
  logic [SLOT_W-1:0]        hash_slot;
  logic [ROW_W-1:0]         next_row;
  chain_t                   chain [CELLS+1];
  logic [CELLS-1:0]         in_window;
  logic [CELLS-1:0]         wr_en;
  cell_ctrl_t               ctrl;
  look_t                    look;
  chain_t                   res;
  logic                     out_free;
  logic                     out_load;
  logic                     probe_first;
  logic                     probe_last;
  logic                     decided;
  logic                     cap_ok;
  logic                     do_insert;
  logic signed [GID_W-1:0]  rsl_gid;
  logic                     rsl_new;
  logic [STATUS_W-1:0]      rsl_status;

  // Channel handshakes
  assign row_in.ready     = (state == S_IDLE);
  assign accept           = row_in.valid && (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_valid;
  assign result.group_id  = out_gid;
  assign result.new_group = out_new;
  assign result.row_index = out_row;
  assign result.status    = out_status;

  assign row_base = row_in.start_table ? '0 : row_count;
  assign next_row = probe_row + ROW_W'(1);

  // Home slot of the accepted row
  gida_hash #(.KEY_WIDTH(KEY_WIDTH)) u_hash (
    .clk      (clk),
    .load     (accept),
    .key      (row_in.key_value[KEY_WIDTH-1:0]),
    .key_null (row_in.key_null),
    .slot     (hash_slot)
  );

  // Chain of probe cells, one bank each, in probe order within a table row
  assign chain[0] = '0;
  assign look     = '{key_null: null_r, epoch: epoch};

  for (genvar b = 0; b < CELLS; b++) begin : g_cell
    assign in_window[b] = probe_first ? (OFF_W'(b) >= probe_off) :
                          probe_last  ? (OFF_W'(b) <  probe_off) : 1'b1;

    gida_cell #(.KEY_WIDTH(KEY_WIDTH), .CELL_IDX(b)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_en     (wr_en[b]),
      .key       (key_r),
      .look      (look),
      .in_window (in_window[b]),
      .chain_in  (chain[b]),
      .chain_out (chain[b+1])
    );
  end

  // Probe decision, memory control and the result word
  always_comb begin
    res         = chain[CELLS];
    out_free    = !out_valid || result.ready;
    probe_first = (probe_cnt == '0);
    probe_last  = (probe_cnt == CNT_W'(ROWS));
    decided     = res.done || probe_last;
    cap_ok      = (group_count < GCNT_W'(GROUP_CAP));
    do_insert   = (state == S_PROBE) && decided && out_free && res.done && !res.hit && cap_ok;
    out_load    = out_free && (((state == S_HASH) && drop_r) ||
                               ((state == S_PROBE) && decided));

    ctrl.rd_en  = ((state == S_HASH) && !drop_r) || ((state == S_PROBE) && !decided);
    ctrl.rd_row = (state == S_HASH) ? hash_slot[SLOT_W-1:OFF_W] : next_row;
    ctrl.wr_row = (state == S_CLEAR) ? clr_row : probe_row;
    if (state == S_CLEAR) begin
      ctrl.wr_meta = '{epoch: EPOCH_SWEPT, key_null: 1'b0, group: '0};
    end else begin
      ctrl.wr_meta = '{epoch: epoch, key_null: null_r, group: group_count[GRP_W-1:0]};
    end
    for (int b = 0; b < CELLS; b++) begin
      wr_en[b] = (state == S_CLEAR) || (do_insert && (res.bank == OFF_W'(b)));
    end

    if (res.done && res.hit) begin
      rsl_gid    = GID_W'(res.group);
      rsl_new    = 1'b0;
      rsl_status = STATUS_GROUPED;
    end else if (res.done && cap_ok) begin
      rsl_gid    = GID_W'(group_count);
      rsl_new    = 1'b1;
      rsl_status = STATUS_GROUPED;
    end else begin
      rsl_gid    = GID_NONE;
      rsl_new    = 1'b0;
      rsl_status = STATUS_FULL;
    end
  end

  // Sequencer, counters, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      drop_null_keys <= 1'b0;
      epoch          <= EPOCH_FIRST;
      group_count    <= '0;
      row_count      <= '0;
      item_held      <= 1'b0;
      clr_row        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        drop_null_keys <= cfg.drop_null_keys;
      end
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        // Sweep one row of every bank per cycle
        S_CLEAR: begin
          clr_row <= clr_row + ROW_W'(1);
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= item_held ? S_HASH : S_IDLE;
          end
        end

        // Take a row, advance the row count, open a new table on request (sweeping first when the epoch wraps)
        S_IDLE: begin
          if (row_in.valid) begin
            key_r     <= row_in.key_value[KEY_WIDTH-1:0];
            null_r    <= row_in.key_null;
            drop_r    <= row_in.key_null && drop_null_keys;
            row_idx_r <= row_base;
            row_count <= (row_base == {ROW_CNT_W{1'b1}}) ? row_base
                                                         : row_base + ROW_CNT_W'(1);
            item_held <= 1'b1;
            if (row_in.start_table) begin
              group_count <= '0;
              if (epoch == EPOCH_MAX) begin
                epoch   <= EPOCH_FIRST;
                clr_row <= '0;
                state   <= S_CLEAR;
              end else begin
                epoch <= epoch + EPOCH_W'(1);
                state <= S_HASH;
              end
            end else begin
              state <= S_HASH;
            end
          end
        end

        // Drop a null key, or start the probe at the home slot
        S_HASH: begin
          if (drop_r) begin
            if (out_free) begin
              out_valid  <= 1'b1;
              out_gid    <= GID_NONE;
              out_new    <= 1'b0;
              out_row    <= row_idx_r;
              out_status <= STATUS_DROPPED;
              item_held  <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            probe_row <= hash_slot[SLOT_W-1:OFF_W];
            probe_off <= hash_slot[OFF_W-1:0];
            probe_cnt <= '0;
            state     <= S_PROBE;
          end
        end

        // Resolve on a hit, a free slot or an exhausted probe, else advance one table row
        S_PROBE: begin
          if (decided) begin
            if (out_free) begin
              out_valid  <= 1'b1;
              out_gid    <= rsl_gid;
              out_new    <= rsl_new;
              out_row    <= row_idx_r;
              out_status <= rsl_status;
              if (do_insert) begin
                group_count <= group_count + GCNT_W'(1);
              end
              item_held <= 1'b0;
              state     <= S_IDLE;
            end
          end else begin
            probe_row <= next_row;
            probe_cnt <= probe_cnt + CNT_W'(1);
          end
        end

        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

### hdl/gida_chk.sv
// Port level checks of the group id assigner and their bind to the top level.
`timescale 1ns / 1ps

module gida_chk import gida_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [GID_W-1:0]  group_id,
  input logic                     new_group,
  input logic [ROW_CNT_W-1:0]     row_index,
  input logic [STATUS_W-1:0]      status
);

  // One row at a time: an accepted row closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("row accepted while previous row still in work");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(group_id) && $stable(new_group)
                                   && $stable(row_index) && $stable(status)))
    else $error("stalled result word changed");

  // A new group carries a real group number
  a_new_is_grouped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_group) |-> (status == STATUS_GROUPED && !group_id[GID_W-1]))
    else $error("new group without a group number");

  // Dropped and rejected rows carry no group
  a_ungrouped_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_GROUPED) |-> (group_id == GID_NONE && !new_group))
    else $error("ungrouped row with a group number");

endmodule

bind group_id_assigner_core gida_chk u_gida_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (row_in.valid),
  .in_ready  (row_in.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .group_id  (result.group_id),
  .new_group (result.new_group),
  .row_index (result.row_index),
  .status    (result.status)
);
